// ----- hw/rtl/ptpd_pkg.sv -----
// ptpd_pkg: word types and fixed widths for the point to plane distance unit
// no dependencies; used by every module of the block by scoped name
`timescale 1ns / 1ps
`default_nettype none

package ptpd_pkg;

   // coordinate and result widths
   localparam int COORD_W = 16;
   localparam int DIST_W  = 17;

   // intermediate widths of the front arithmetic
   localparam int DIFF_W  = COORD_W + 1;        // edge and offset vectors
   localparam int PROD_W  = 2 * DIFF_W;         // cross product terms
   localparam int NORM_W  = PROD_W + 1;         // normal components
   localparam int ABSN_W  = PROD_W;             // normal magnitude per axis
   localparam int HALF_N  = DIFF_W;             // low half of a split normal
   localparam int NHI_W   = NORM_W - HALF_N;    // signed high half of the normal
   localparam int NPP_W   = NHI_W + DIFF_W;     // partial of normal times offset
   localparam int AHI_W   = ABSN_W - HALF_N;    // high half of normal magnitude
   localparam int SQ_W    = 2 * HALF_N;         // partial of a normal square
   localparam int DOT_W   = NORM_W + DIFF_W + 2;// signed plane offset
   localparam int DOTH_W  = DOT_W / 2;          // half of the offset magnitude
   localparam int DSQ_W   = 2 * DOTH_W;         // partial of the offset square
   localparam int NN_W    = 2 * ABSN_W + 2;     // squared normal length
   localparam int D2_W    = 2 * DOT_W;          // squared plane offset

   // decoupling queue
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = 2;
   localparam int QCNT_W  = 3;

   // input word
   typedef struct packed {
      logic signed [COORD_W-1:0] vertex_a_x;
      logic signed [COORD_W-1:0] vertex_a_y;
      logic signed [COORD_W-1:0] vertex_a_z;
      logic signed [COORD_W-1:0] vertex_b_x;
      logic signed [COORD_W-1:0] vertex_b_y;
      logic signed [COORD_W-1:0] vertex_b_z;
      logic signed [COORD_W-1:0] vertex_c_x;
      logic signed [COORD_W-1:0] vertex_c_y;
      logic signed [COORD_W-1:0] vertex_c_z;
      logic signed [COORD_W-1:0] query_x;
      logic signed [COORD_W-1:0] query_y;
      logic signed [COORD_W-1:0] query_z;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              degenerate;
   } rsp_word_type;

   // classified word between front and back
   typedef struct packed {
      logic [D2_W-1:0] d2;
      logic [NN_W-1:0] nn;
      logic            degenerate;
   } mid_word_type;

   // running state of the root search
   typedef struct packed {
      logic [D2_W-1:0]   rem;
      logic [D2_W-1:0]   qn;
      logic [NN_W-1:0]   nn;
      logic [DIST_W-1:0] q;
      logic              degenerate;
   } root_state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ptpd_front.sv -----
// ptpd_front: eight stage arithmetic pipeline, forms the squared plane offset and
// squared normal length and flags a zero normal; depends on ptpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptpd_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   input  ptpd_pkg::req_word_type in_data,
   output logic                  out_valid,
   input  wire                   out_ready,
   output ptpd_pkg::mid_word_type out_data
);

   localparam int NSTAGE = 8;

   logic [NSTAGE-1:0] v_ff;
   logic              en;

   // whole pipeline moves unless the last word is held
   assign en       = !v_ff[NSTAGE-1] || out_ready;
   assign in_ready = en;

   // vertex fields as small arrays
   logic signed [ptpd_pkg::COORD_W-1:0] pa [3];
   logic signed [ptpd_pkg::COORD_W-1:0] pb [3];
   logic signed [ptpd_pkg::COORD_W-1:0] pc [3];
   logic signed [ptpd_pkg::COORD_W-1:0] pp [3];

   assign pa[0] = in_data.vertex_a_x;
   assign pa[1] = in_data.vertex_a_y;
   assign pa[2] = in_data.vertex_a_z;
   assign pb[0] = in_data.vertex_b_x;
   assign pb[1] = in_data.vertex_b_y;
   assign pb[2] = in_data.vertex_b_z;
   assign pc[0] = in_data.vertex_c_x;
   assign pc[1] = in_data.vertex_c_y;
   assign pc[2] = in_data.vertex_c_z;
   assign pp[0] = in_data.query_x;
   assign pp[1] = in_data.query_y;
   assign pp[2] = in_data.query_z;

   // stage registers
   logic signed [ptpd_pkg::DIFF_W-1:0] ab_ff [3];
   logic signed [ptpd_pkg::DIFF_W-1:0] ac_ff [3];
   logic signed [ptpd_pkg::DIFF_W-1:0] ap1_ff [3];
   logic signed [ptpd_pkg::PROD_W-1:0] m_ff [6];
   logic signed [ptpd_pkg::DIFF_W-1:0] ap2_ff [3];
   logic signed [ptpd_pkg::NORM_W-1:0] n_ff [3];
   logic signed [ptpd_pkg::DIFF_W-1:0] ap3_ff [3];
   logic signed [ptpd_pkg::NPP_W-1:0]  plo_ff [3];
   logic signed [ptpd_pkg::NPP_W-1:0]  phi_ff [3];
   logic [ptpd_pkg::ABSN_W-1:0]        absn_ff [3];
   logic signed [ptpd_pkg::DOT_W-1:0]  dot_ff;
   logic [ptpd_pkg::SQ_W-1:0]          hh_ff [3];
   logic [ptpd_pkg::SQ_W-1:0]          hl_ff [3];
   logic [ptpd_pkg::SQ_W-1:0]          ll_ff [3];
   logic [ptpd_pkg::NN_W-1:0]          nn6_ff;
   logic [ptpd_pkg::DOT_W-1:0]         absdot_ff;
   logic [ptpd_pkg::DSQ_W-1:0]         dhh_ff;
   logic [ptpd_pkg::DSQ_W-1:0]         dhl_ff;
   logic [ptpd_pkg::DSQ_W-1:0]         dll_ff;
   logic [ptpd_pkg::NN_W-1:0]          nn7_ff;
   logic                               degen7_ff;
   logic [ptpd_pkg::D2_W-1:0]          d2_ff;
   logic [ptpd_pkg::NN_W-1:0]          nn8_ff;
   logic                               degen8_ff;

   // next values
   logic signed [ptpd_pkg::NORM_W-1:0] neg_n [3];
   logic [ptpd_pkg::ABSN_W-1:0]        absn_in [3];
   logic signed [ptpd_pkg::DOT_W-1:0]  dot_in;
   logic [ptpd_pkg::NN_W-1:0]          nn_in;
   logic signed [ptpd_pkg::DOT_W-1:0]  neg_dot;
   logic [ptpd_pkg::DOT_W-1:0]         absdot_in;
   logic [ptpd_pkg::D2_W-1:0]          d2_in;

   // normal magnitude per axis
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         neg_n[k]   = -n_ff[k];
         absn_in[k] = n_ff[k][ptpd_pkg::NORM_W-1] ? neg_n[k][ptpd_pkg::ABSN_W-1:0]
                                                   : n_ff[k][ptpd_pkg::ABSN_W-1:0];
      end
   end

   // plane offset from split partial products
   always_comb begin
      dot_in = '0;
      for (int k = 0; k < 3; k++) begin
         dot_in = dot_in + (ptpd_pkg::DOT_W'(phi_ff[k]) <<< ptpd_pkg::HALF_N)
                         + ptpd_pkg::DOT_W'(plo_ff[k]);
      end
   end

   // squared normal length from split partial products
   always_comb begin
      nn_in = '0;
      for (int k = 0; k < 3; k++) begin
         nn_in = nn_in + (ptpd_pkg::NN_W'(hh_ff[k]) << (2 * ptpd_pkg::HALF_N))
                       + (ptpd_pkg::NN_W'(hl_ff[k]) << (ptpd_pkg::HALF_N + 1))
                       + ptpd_pkg::NN_W'(ll_ff[k]);
      end
   end

   // offset magnitude and its square
   assign neg_dot   = -dot_ff;
   assign absdot_in = dot_ff[ptpd_pkg::DOT_W-1] ? neg_dot : dot_ff;
   assign d2_in     = (ptpd_pkg::D2_W'(dhh_ff) << (2 * ptpd_pkg::DOTH_W))
                    + (ptpd_pkg::D2_W'(dhl_ff) << (ptpd_pkg::DOTH_W + 1))
                    + ptpd_pkg::D2_W'(dll_ff);

   // datapath registers
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            ab_ff[k]  <= ptpd_pkg::DIFF_W'(pb[k]) - ptpd_pkg::DIFF_W'(pa[k]);
            ac_ff[k]  <= ptpd_pkg::DIFF_W'(pc[k]) - ptpd_pkg::DIFF_W'(pa[k]);
            ap1_ff[k] <= ptpd_pkg::DIFF_W'(pp[k]) - ptpd_pkg::DIFF_W'(pa[k]);
            ap2_ff[k] <= ap1_ff[k];
            ap3_ff[k] <= ap2_ff[k];
            plo_ff[k] <= $signed({1'b0, n_ff[k][ptpd_pkg::HALF_N-1:0]}) * ap3_ff[k];
            phi_ff[k] <= $signed(n_ff[k][ptpd_pkg::NORM_W-1:ptpd_pkg::HALF_N]) * ap3_ff[k];
            absn_ff[k] <= absn_in[k];
            hh_ff[k]  <= absn_ff[k][ptpd_pkg::ABSN_W-1:ptpd_pkg::HALF_N]
                       * absn_ff[k][ptpd_pkg::ABSN_W-1:ptpd_pkg::HALF_N];
            hl_ff[k]  <= absn_ff[k][ptpd_pkg::ABSN_W-1:ptpd_pkg::HALF_N]
                       * absn_ff[k][ptpd_pkg::HALF_N-1:0];
            ll_ff[k]  <= absn_ff[k][ptpd_pkg::HALF_N-1:0]
                       * absn_ff[k][ptpd_pkg::HALF_N-1:0];
         end
         // cross product terms
         m_ff[0] <= ab_ff[1] * ac_ff[2];
         m_ff[1] <= ab_ff[2] * ac_ff[1];
         m_ff[2] <= ab_ff[2] * ac_ff[0];
         m_ff[3] <= ab_ff[0] * ac_ff[2];
         m_ff[4] <= ab_ff[0] * ac_ff[1];
         m_ff[5] <= ab_ff[1] * ac_ff[0];
         n_ff[0] <= ptpd_pkg::NORM_W'(m_ff[0]) - ptpd_pkg::NORM_W'(m_ff[1]);
         n_ff[1] <= ptpd_pkg::NORM_W'(m_ff[2]) - ptpd_pkg::NORM_W'(m_ff[3]);
         n_ff[2] <= ptpd_pkg::NORM_W'(m_ff[4]) - ptpd_pkg::NORM_W'(m_ff[5]);
         dot_ff    <= dot_in;
         nn6_ff    <= nn_in;
         absdot_ff <= absdot_in;
         dhh_ff    <= absdot_ff[ptpd_pkg::DOT_W-1:ptpd_pkg::DOTH_W]
                    * absdot_ff[ptpd_pkg::DOT_W-1:ptpd_pkg::DOTH_W];
         dhl_ff    <= absdot_ff[ptpd_pkg::DOT_W-1:ptpd_pkg::DOTH_W]
                    * absdot_ff[ptpd_pkg::DOTH_W-1:0];
         dll_ff    <= absdot_ff[ptpd_pkg::DOTH_W-1:0] * absdot_ff[ptpd_pkg::DOTH_W-1:0];
         nn7_ff    <= nn6_ff;
         degen7_ff <= (nn6_ff == '0);
         d2_ff     <= d2_in;
         nn8_ff    <= nn7_ff;
         degen8_ff <= degen7_ff;
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NSTAGE-2:0], in_valid};
      end
   end

   assign out_valid           = v_ff[NSTAGE-1];
   assign out_data.d2         = d2_ff;
   assign out_data.nn         = nn8_ff;
   assign out_data.degenerate = degen8_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/ptpd_queue.sv -----
// ptpd_queue: short first-in first-out queue between front and back
// depends on ptpd_pkg for the word type and depth
`timescale 1ns / 1ps
`default_nettype none

module ptpd_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   input  ptpd_pkg::mid_word_type in_data,
   output logic                  out_valid,
   input  wire                   out_ready,
   output ptpd_pkg::mid_word_type out_data
);

   ptpd_pkg::mid_word_type mem_ff [ptpd_pkg::QDEPTH];
   logic [ptpd_pkg::QPTR_W-1:0] wr_ptr_ff;
   logic [ptpd_pkg::QPTR_W-1:0] rd_ptr_ff;
   logic [ptpd_pkg::QCNT_W-1:0] count_ff;
   logic push;
   logic pop;

   assign in_ready  = (count_ff != ptpd_pkg::QCNT_W'(ptpd_pkg::QDEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // count tracks push and pop
   a_push_only: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not rise on push");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not fall on pop");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers differ while empty");

endmodule

`default_nettype wire

// ----- hw/rtl/ptpd_back.sv -----
// ptpd_back: pipelined bit-by-bit root search, one result bit per stage
// finds the largest q with q*q*nn <= d2; depends on ptpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptpd_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   input  ptpd_pkg::mid_word_type in_data,
   output logic                  out_valid,
   input  wire                   out_ready,
   output ptpd_pkg::rsp_word_type out_data
);

   localparam int NSTAGE = ptpd_pkg::DIST_W;

   ptpd_pkg::root_state_type st_ff [NSTAGE];
   ptpd_pkg::root_state_type st_in [NSTAGE];
   ptpd_pkg::root_state_type st_cur [NSTAGE];
   logic [NSTAGE-1:0] v_ff;
   logic              en;

   // last stage doubles as the output register
   assign en       = !v_ff[NSTAGE-1] || out_ready;
   assign in_ready = en;

   // starting state from the queue head
   always_comb begin
      st_cur[0].rem        = in_data.d2;
      st_cur[0].qn         = '0;
      st_cur[0].nn         = in_data.nn;
      st_cur[0].q          = '0;
      st_cur[0].degenerate = in_data.degenerate;
   end

   for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
      localparam int B = NSTAGE - 1 - s;
      logic [ptpd_pkg::D2_W-1:0] trial;
      logic [ptpd_pkg::D2_W-1:0] nn_w;

      if (s > 0) begin : g_link
         assign st_cur[s] = st_ff[s-1];
      end

      // (q + 2^B)^2 nn - q^2 nn = q*nn*2^(B+1) + nn*2^(2B)
      assign nn_w  = ptpd_pkg::D2_W'(st_cur[s].nn);
      assign trial = (st_cur[s].qn << (B + 1)) + (nn_w << (2 * B));

      always_comb begin
         st_in[s] = st_cur[s];
         if (trial <= st_cur[s].rem) begin
            st_in[s].rem = st_cur[s].rem - trial;
            st_in[s].qn  = st_cur[s].qn + (nn_w << B);
            st_in[s].q   = st_cur[s].q | (ptpd_pkg::DIST_W'(1) << B);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NSTAGE-2:0], in_valid};
      end
   end

   // zero normal reports distance zero
   assign out_valid           = v_ff[NSTAGE-1];
   assign out_data.distance   = st_ff[NSTAGE-1].degenerate ? '0 : st_ff[NSTAGE-1].q;
   assign out_data.degenerate = st_ff[NSTAGE-1].degenerate;

endmodule

`default_nettype wire

// ----- hw/rtl/point_to_plane_distance_unit.sv -----
// point_to_plane_distance_unit: top level, front pipeline, queue and root search
// depends on ptpd_pkg, ptpd_front, ptpd_queue and ptpd_back
`timescale 1ns / 1ps
`default_nettype none

// Distance from a query point to the plane through three vertices, all signed
// Q7.8. The result is |n.(P-A)| / |n| with n = (B-A) x (C-A), truncated toward
// zero in the same scale; a zero normal gives distance 0 with degenerate set.
// One word is taken per cycle unless the output is held back, fully pipelined:
// an eight stage arithmetic front (split multipliers for the wide squares) feeds
// a four word queue, then a seventeen stage root search resolves one distance
// bit per stage. The queue lets the front keep taking words while the result
// side is held, until the queue fills.

module point_to_plane_distance_unit (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  ptpd_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output ptpd_pkg::rsp_word_type rsp_data
);

   logic                   front_valid;
   logic                   front_ready;
   ptpd_pkg::mid_word_type front_data;
   logic                   back_valid;
   logic                   back_ready;
   ptpd_pkg::mid_word_type back_data;

   // classification front
   ptpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   // decoupling queue
   ptpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_data  (back_data)
   );

   // root search back
   ptpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (back_valid),
      .in_ready  (back_ready),
      .in_data   (back_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire
